/* design/tqmf_pkg.sv */
package tqmf_pkg;

  localparam int CHANNELS   = 4;
  localparam int WINDOW     = 5;
  localparam int NUM_FIELDS = 4;

  localparam int SAMPLE_W = 12;
  localparam int THRESH_W = 12;
  localparam int TRIT_W   = 2;
  localparam int KEY_W    = 7;

  localparam int SUM_W = $clog2(WINDOW + 1) + 1;
  localparam int POS_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  localparam int IN_DATA_W  = ((NUM_FIELDS * SAMPLE_W + 7) / 8) * 8;
  localparam int OUT_BITS   = NUM_FIELDS * TRIT_W + KEY_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = THRESH_W;

  localparam logic [THRESH_W-1:0] LOW_RESET  = THRESH_W'(1365);
  localparam logic [THRESH_W-1:0] HIGH_RESET = THRESH_W'(2730);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOW_THRESHOLD  = 2'd0,
    CFG_HIGH_THRESHOLD = 2'd1
  } cfg_reg_e;

  typedef logic signed [TRIT_W-1:0] trit_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic [SAMPLE_W-1:0]      sample_t;
  typedef logic [THRESH_W-1:0]      thresh_t;
  typedef logic [KEY_W-1:0]         key_t;

  localparam trit_t MINUS_TRIT = 2'sb11;
  localparam trit_t NULL_TRIT  = 2'sb00;
  localparam trit_t PLUS_TRIT  = 2'sb01;

  function automatic key_t make_key(input trit_t filt [CHANNELS]);
    int acc;
    int pw;
    acc = 0;
    pw  = 1;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      acc = acc + (int'(filt[ch]) + 1) * pw;
      pw  = pw * 3;
    end
    return KEY_W'(acc);
  endfunction

endpackage

/* design/tqmf_quant.sv */
module tqmf_quant (
  input  tqmf_pkg::sample_t samples_i [tqmf_pkg::NUM_FIELDS],
  input  tqmf_pkg::thresh_t low_i,
  input  tqmf_pkg::thresh_t high_i,
  output tqmf_pkg::trit_t   trits_o [tqmf_pkg::CHANNELS]
);
  import tqmf_pkg::*;

  for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_ch
    if (ch < NUM_FIELDS) begin : g_live
      always_comb begin
        priority if (samples_i[ch] <= low_i) begin
          trits_o[ch] = MINUS_TRIT;
        end else if (samples_i[ch] >= high_i) begin
          trits_o[ch] = PLUS_TRIT;
        end else begin
          trits_o[ch] = NULL_TRIT;
        end
      end
    end else begin : g_idle
      assign trits_o[ch] = NULL_TRIT;
    end
  end

endmodule

/* design/tqmf_window.sv */
module tqmf_window (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            update_i,
  input  tqmf_pkg::trit_t trits_i [tqmf_pkg::CHANNELS],
  output tqmf_pkg::trit_t filt_o  [tqmf_pkg::CHANNELS]
);
  import tqmf_pkg::*;

  trit_t             store_q [CHANNELS][WINDOW];
  sum_t              sum_q   [CHANNELS];
  sum_t              sum_d   [CHANNELS];
  logic [POS_W-1:0]  pos_q;
  logic [POS_W-1:0]  pos_d;

  always_comb begin
    for (int ch = 0; ch < CHANNELS; ch++) begin
      sum_d[ch] = sum_q[ch] + sum_t'(trits_i[ch]) - sum_t'(store_q[ch][pos_q]);
      if (sum_d[ch] > sum_t'(0)) begin
        filt_o[ch] = PLUS_TRIT;
      end else if (sum_d[ch] < sum_t'(0)) begin
        filt_o[ch] = MINUS_TRIT;
      end else begin
        filt_o[ch] = NULL_TRIT;
      end
    end
    pos_d = (pos_q == POS_W'(WINDOW - 1)) ? '0 : pos_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      for (int ch = 0; ch < CHANNELS; ch++) begin
        sum_q[ch] <= '0;
        for (int w = 0; w < WINDOW; w++) begin
          store_q[ch][w] <= NULL_TRIT;
        end
      end
    end else if (update_i) begin
      pos_q <= pos_d;
      for (int ch = 0; ch < CHANNELS; ch++) begin
        sum_q[ch]          <= sum_d[ch];
        store_q[ch][pos_q] <= trits_i[ch];
      end
    end
  end

endmodule

/* design/ternary_quantize_majority_filter_unit.sv */
// Each item passes through the input register and then the result register before its
// result is offered on the output.
// Throughput: one item per cycle; while a result is stalled the input register
// still takes one more item, and then the input stalls.
// Reset clears all window trits, the running sums and the write position,
// and loads the thresholds with 1365 and 2730.
module ternary_quantize_majority_filter_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // Fields from bit 0: sample_ch0, sample_ch1, sample_ch2, sample_ch3.
  input  logic [tqmf_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // Fields from bit 0: filtered_ch0, filtered_ch1, filtered_ch2, filtered_ch3,
  // state_key.
  output logic [tqmf_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [tqmf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tqmf_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import tqmf_pkg::*;

  thresh_t low_q;
  thresh_t high_q;

  logic    in_valid_q;
  sample_t samples_q [NUM_FIELDS];
  logic    out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic [OUT_DATA_W-1:0] out_data_d;

  logic  advance;
  trit_t trits [CHANNELS];
  trit_t filt  [CHANNELS];

  assign cfg_ready_o   = 1'b1;
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= LOW_RESET;
      high_q <= HIGH_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_LOW_THRESHOLD:  low_q  <= cfg_data_i;
        CFG_HIGH_THRESHOLD: high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      for (int f = 0; f < NUM_FIELDS; f++) begin
        samples_q[f] <= s_axis_tdata[f*SAMPLE_W +: SAMPLE_W];
      end
    end
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  tqmf_quant u_quant (
    .samples_i (samples_q),
    .low_i     (low_q),
    .high_i    (high_q),
    .trits_o   (trits)
  );

  tqmf_window u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .update_i (advance),
    .trits_i  (trits),
    .filt_o   (filt)
  );

  for (genvar f = 0; f < NUM_FIELDS; f++) begin : g_out
    if (f < CHANNELS) begin : g_live
      assign out_data_d[f*TRIT_W +: TRIT_W] = filt[f];
    end else begin : g_zero
      assign out_data_d[f*TRIT_W +: TRIT_W] = '0;
    end
  end

  assign out_data_d[NUM_FIELDS*TRIT_W +: KEY_W] = make_key(filt);

  if (OUT_DATA_W > OUT_BITS) begin : g_pad
    assign out_data_d[OUT_DATA_W-1:OUT_BITS] = '0;
  end

endmodule

/* test/ternary_quantize_majority_filter_unit_test.sv */
module ternary_quantize_majority_filter_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tqmf_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 64;
  localparam int PHASES         = 5;
  localparam int PHASE_ITEMS    = 147;
  localparam int DIRECTED_ROWS  = 23;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  // On a threshold row, s0 carries the low threshold and s1 the high one.
  typedef struct packed {
    row_kind_e kind;
    sample_t   s0;
    sample_t   s1;
    sample_t   s2;
    sample_t   s3;
    logic      pinned;
    trit_t     pin_trit;
    key_t      pin_key;
  } stim_row_t;

  typedef struct packed {
    key_t                    state_key;
    trit_t [NUM_FIELDS-1:0] filt;
  } vote_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  cfg_reg_e              cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  ternary_quantize_majority_filter_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  int      win_trit [CHANNELS][WINDOW];
  int      win_sum [CHANNELS];
  int      win_pos;
  thresh_t low_thr;
  thresh_t high_thr;

  vote_t     pending_votes [$];
  int        mismatch_count;
  int        quiet_cycles;
  int        send_idle_pct;
  int        recv_stall_pct;
  bit        hold_armed;
  bit        hold_done;
  logic      item_pinned;
  vote_t     item_pin_vote;
  vote_t     vote_got;
  vote_t     vote_want;
  vote_t     vote_pred;
  stim_row_t directed_rows [DIRECTED_ROWS];

  function automatic vote_t absorb_samples(input logic [IN_DATA_W-1:0] d);
    vote_t   r;
    sample_t s;
    int      t;
    int      f;
    int      key;
    int      pw;
    r   = '0;
    key = 0;
    pw  = 1;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      t = 0;
      if (ch < NUM_FIELDS) begin
        s = d[ch*SAMPLE_W +: SAMPLE_W];
        if (s <= low_thr) begin
          t = -1;
        end else if (s >= high_thr) begin
          t = 1;
        end
      end
      win_sum[ch] = win_sum[ch] + t - win_trit[ch][win_pos];
      win_trit[ch][win_pos] = t;
      f = (win_sum[ch] > 0) ? 1 : ((win_sum[ch] < 0) ? -1 : 0);
      if (ch < NUM_FIELDS) begin
        r.filt[ch] = trit_t'(f);
      end
      key = key + (f + 1) * pw;
      pw  = pw * 3;
    end
    win_pos     = (win_pos + 1) % WINDOW;
    r.state_key = key_t'(key);
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_LOW_THRESHOLD:  low_thr = cfg_data_i;
          CFG_HIGH_THRESHOLD: high_thr = cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        vote_pred = absorb_samples(s_axis_tdata);
        pending_votes.push_back(item_pinned ? item_pin_vote : vote_pred);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_votes.size() == 0) begin
          flag_mismatch("result with no item pending", int'(m_axis_tdata), 0);
        end else begin
          vote_want = pending_votes.pop_front();
          vote_got  = vote_t'(m_axis_tdata[OUT_BITS-1:0]);
          for (int ch = 0; ch < NUM_FIELDS; ch++) begin
            if (vote_got.filt[ch] !== vote_want.filt[ch]) begin
              flag_mismatch($sformatf("filtered_ch%0d", ch), int'(vote_got.filt[ch]),
                            int'(vote_want.filt[ch]));
            end
          end
          if (vote_got.state_key !== vote_want.state_key) begin
            flag_mismatch("state_key", int'(vote_got.state_key), int'(vote_want.state_key));
          end
          if ((m_axis_tdata >> OUT_BITS) !== '0) begin
            flag_mismatch("tdata padding", int'(m_axis_tdata >> OUT_BITS), 0);
          end
        end
      end
    end
  end

  initial begin
    quiet_cycles = 0;
    @(posedge rst_ni);
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("%0t: no handshake for %0d cycles", $realtime, WATCHDOG_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // The receiver stalls at random, and holds off once for a long stretch
  // while the sender keeps offering items, so that the pipeline fills up.
  initial begin
    m_axis_tready = 1'b0;
    hold_done     = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_armed && !hold_done) begin
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic offer_samples(input logic [IN_DATA_W-1:0] d, input logic pinned,
                               input vote_t pin_vote);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    item_pinned   <= pinned;
    item_pin_vote <= pin_vote;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain_and_set_thresholds(input thresh_t lo, input thresh_t hi);
    s_axis_tvalid <= 1'b0;
    while (pending_votes.size() != 0) @(negedge clk_i);
    for (int k = 0; k < 2; k++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= (k == 0) ? CFG_LOW_THRESHOLD : CFG_HIGH_THRESHOLD;
      cfg_data_i  <= (k == 0) ? lo : hi;
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      @(negedge clk_i);
    end
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    stim_row_t            row;
    vote_t                pin;
    logic [IN_DATA_W-1:0] d;
    int                   v;
    int                   last_smp [NUM_FIELDS];
    int                   lo;
    int                   hi;
    int                   send_pcts [PHASES];
    int                   recv_pcts [PHASES];

    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = CFG_LOW_THRESHOLD;
    cfg_data_i     = '0;
    item_pinned    = 1'b0;
    item_pin_vote  = '0;
    mismatch_count = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_armed     = 1'b0;
    foreach (win_trit[c, w]) win_trit[c][w] = 0;
    foreach (win_sum[c]) win_sum[c] = 0;
    win_pos  = 0;
    low_thr  = LOW_RESET;
    high_thr = HIGH_RESET;
    foreach (last_smp[c]) last_smp[c] = 0;
    send_pcts = '{0, 61, 0, 7, 0};
    recv_pcts = '{0, 0, 61, 7, 0};

    directed_rows = '{
      '{ROW_ITEM, 12'd0,    12'd0,    12'd0,    12'd0,    1'b1, MINUS_TRIT, 7'd0},
      '{ROW_ITEM, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b1, NULL_TRIT,  7'd40},
      '{ROW_ITEM, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b1, PLUS_TRIT,  7'd80},
      '{ROW_ITEM, 12'd1365, 12'd1366, 12'd2729, 12'd2730, 1'b0, NULL_TRIT,  7'd0},
      '{ROW_ITEM, 12'd2730, 12'd2729, 12'd1366, 12'd1365, 1'b0, NULL_TRIT,  7'd0},
      '{ROW_ITEM, 12'd0,    12'd4095, 12'd0,    12'd4095, 1'b0, NULL_TRIT,  7'd0},
      '{ROW_ITEM, 12'd4095, 12'd0,    12'd4095, 12'd0,    1'b0, NULL_TRIT,  7'd0},
      '{ROW_ITEM, 12'h555,  12'hAAA,  12'h5A5,  12'hA5A,  1'b0, NULL_TRIT,  7'd0},
      '{ROW_ITEM, 12'hFFF,  12'h000,  12'h800,  12'h7FF,  1'b0, NULL_TRIT,  7'd0},
      '{ROW_CFG,  12'd3000, 12'd1000, 12'd0,    12'd0,    1'b0, NULL_TRIT,  7'd0},
      '{ROW_ITEM, 12'd2000, 12'd500,  12'd3500, 12'd1000, 1'b0, NULL_TRIT,  7'd0},
      '{ROW_ITEM, 12'd3000, 12'd2999, 12'd999,  12'd1001, 1'b0, NULL_TRIT,  7'd0},
      '{ROW_CFG,  12'd0,    12'd4095, 12'd0,    12'd0,    1'b0, NULL_TRIT,  7'd0},
      '{ROW_ITEM, 12'd0,    12'd1,    12'd4094, 12'd4095, 1'b0, NULL_TRIT,  7'd0},
      '{ROW_ITEM, 12'd4095, 12'd0,    12'd2048, 12'd1,    1'b0, NULL_TRIT,  7'd0},
      '{ROW_CFG,  12'd4095, 12'd0,    12'd0,    12'd0,    1'b0, NULL_TRIT,  7'd0},
      '{ROW_ITEM, 12'd0,    12'd4095, 12'd2048, 12'd1,    1'b0, NULL_TRIT,  7'd0},
      '{ROW_CFG,  12'd0,    12'd0,    12'd0,    12'd0,    1'b0, NULL_TRIT,  7'd0},
      '{ROW_ITEM, 12'd0,    12'd1,    12'd2,    12'd4095, 1'b0, NULL_TRIT,  7'd0},
      '{ROW_CFG,  12'd4095, 12'd4095, 12'd0,    12'd0,    1'b0, NULL_TRIT,  7'd0},
      '{ROW_ITEM, 12'd4095, 12'd0,    12'd1,    12'd4094, 1'b0, NULL_TRIT,  7'd0},
      '{ROW_CFG,  12'd1365, 12'd2730, 12'd0,    12'd0,    1'b0, NULL_TRIT,  7'd0},
      '{ROW_ITEM, 12'd1,    12'd2,    12'd3,    12'd4,    1'b0, NULL_TRIT,  7'd0}
    };

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      row = directed_rows[r];
      if (row.kind == ROW_CFG) begin
        drain_and_set_thresholds(row.s0, row.s1);
      end else begin
        pin.filt      = {NUM_FIELDS{row.pin_trit}};
        pin.state_key = row.pin_key;
        offer_samples({row.s3, row.s2, row.s1, row.s0}, row.pinned, pin);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      if (p == PHASES - 1) begin
        lo = $urandom_range(4095, 2048);
        hi = $urandom_range(2047, 0);
      end else begin
        lo = $urandom_range(3000, 0);
        hi = lo + $urandom_range(4095 - lo, 1);
      end
      drain_and_set_thresholds(thresh_t'(lo), thresh_t'(hi));
      send_idle_pct  = send_pcts[p];
      recv_stall_pct = recv_pcts[p];
      if (p == 3) begin
        hold_armed = 1'b1;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        for (int ch = 0; ch < NUM_FIELDS; ch++) begin
          case ($urandom_range(7))
            0, 1:    v = $urandom_range(4095);
            2:       v = lo + int'($urandom_range(2)) - 1;
            3:       v = hi + int'($urandom_range(2)) - 1;
            default: v = last_smp[ch];
          endcase
          if (v < 0) begin
            v = 0;
          end else if (v > 4095) begin
            v = 4095;
          end
          last_smp[ch] = v;
          d[ch*SAMPLE_W +: SAMPLE_W] = sample_t'(v);
        end
        offer_samples(d, 1'b0, '0);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending_votes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
